@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the sorted list engine.
// No dependencies; each user supplies clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define SLE_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

@@ rtl/sle_pkg.sv @@
// Shared constants and types for the sorted list engine.
// No dependencies.
package sle_pkg;

  localparam int CAPACITY = 64;
  localparam int ValW     = 32;
  localparam int ActW     = 3;
  localparam int PosW     = 6;
  localparam int CountW   = $clog2(CAPACITY + 1);
  localparam int IdxW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CmpW     = (PosW > CountW) ? PosW : CountW;

  // gather tree: groups of cells reduced in the first stage
  localparam int GroupN   = 8;
  localparam int Groups   = (CAPACITY + GroupN - 1) / GroupN;

  // port packing
  localparam int InDataW  = ((ValW + PosW + 7) / 8) * 8;
  localparam int OutBits  = ValW + 1 + CountW;
  localparam int OutDataW = ((OutBits + 7) / 8) * 8;

  typedef enum logic [ActW-1:0] {
    ACT_INSERT  = 3'd0,
    ACT_POP_MIN = 3'd1,
    ACT_POP_MAX = 3'd2,
    ACT_READ    = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;      // ordered insert, shift right above the slot
    logic pop_min;  // shift everything one cell toward the head
  } sle_cmd_t;

endpackage

@@ rtl/sorted_list_engine.sv @@
// Sorted list engine: a double-ended priority queue of up to CAPACITY signed
// 32-bit values kept in ascending order in a chain of cells. Each item carries
// an action in tuser (insert, remove smallest, remove largest, read at index,
// clear) and returns one item: value, ok flag and element count after the
// action. One item is in flight at a time: an item is accepted when the block
// is idle, the result is registered through the StGather and StOut states,
// and s_axis_tready returns the cycle after the result is taken, so the block
// takes no new item before the last result has gone out. The selected cell
// is read by the two-stage gather tree. Inserts and remove-smallest update
// every cell at once in the accept cycle; remove largest only lowers the count.
// Depends on sle_pkg, sle_cell, sle_gather and assert_macros.svh.
`include "assert_macros.svh"

module sorted_list_engine import sle_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // value[31:0], position[37:32], pad
  input  logic [ActW-1:0]     s_axis_tuser,   // action[2:0]
  // result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // result_value[31:0], ok[32],
                                              // element_count[39:33], pad
);

  // control FSM
  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StGather = 2'd1;
  localparam logic [1:0] StOut    = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [CountW-1:0]      count_q, count_d;
  logic                   ok_q, ok_d;
  logic                   rv_en_q, rv_en_d;   // result carries a stored value
  logic signed [ValW-1:0] res_q;
  logic [IdxW-1:0]        idx;

  logic                   accept;
  logic                   out_done;
  action_e                act;
  logic signed [ValW-1:0] in_value;
  logic [PosW-1:0]        in_pos;
  logic                   full, empty, pos_ok;
  sle_cmd_t               cmd;

  logic signed [ValW-1:0] cell_val [CAPACITY];
  logic                   cell_gt  [CAPACITY];
  logic signed [ValW-1:0] gather_data;

  assign act      = action_e'(s_axis_tuser);
  assign in_value = s_axis_tdata[ValW-1:0];
  assign in_pos   = s_axis_tdata[ValW+PosW-1:ValW];

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state_q == StOut);
  assign out_done      = m_axis_tvalid && m_axis_tready;

  assign full   = (count_q == CountW'(CAPACITY));
  assign empty  = (count_q == '0);
  assign pos_ok = (CmpW'(in_pos) < CmpW'(count_q));

  // action decode: next count, ok flag, cell command, gather index
  always_comb begin
    count_d = count_q;
    ok_d    = 1'b0;
    rv_en_d = 1'b0;
    cmd     = '0;
    idx     = '0;
    unique case (act)
      ACT_INSERT: begin
        if (!full) begin
          cmd.ins = 1'b1;
          count_d = count_q + 1'b1;
          ok_d    = 1'b1;
        end
      end
      ACT_POP_MIN: begin
        if (!empty) begin
          cmd.pop_min = 1'b1;
          count_d     = count_q - 1'b1;
          ok_d        = 1'b1;
          rv_en_d     = 1'b1;
        end
      end
      ACT_POP_MAX: begin
        idx = IdxW'(count_q - 1'b1);
        if (!empty) begin
          count_d = count_q - 1'b1;
          ok_d    = 1'b1;
          rv_en_d = 1'b1;
        end
      end
      ACT_READ: begin
        idx = IdxW'(in_pos);
        if (pos_ok) begin
          ok_d    = 1'b1;
          rv_en_d = 1'b1;
        end
      end
      ACT_CLEAR: begin
        count_d = '0;
        ok_d    = 1'b1;
      end
      default: ;
    endcase
    if (!accept) begin
      cmd     = '0;
      count_d = count_q;
      ok_d    = ok_q;
      rv_en_d = rv_en_q;
    end
  end

  // cell chain; head of the chain holds the smallest value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   left_gt;
    logic signed [ValW-1:0] left_val;
    logic signed [ValW-1:0] right_val;

    if (i == 0) begin : g_head
      assign left_gt  = 1'b0;
      assign left_val = in_value;
    end else begin : g_body
      assign left_gt  = cell_gt[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_val = cell_val[i];
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    sle_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .valid_i     (CountW'(i) < count_q),
      .x_i         (in_value),
      .left_val_i  (left_val),
      .left_gt_i   (left_gt),
      .right_val_i (right_val),
      .val_o       (cell_val[i]),
      .gt_o        (cell_gt[i])
    );
  end

  // reads the cells before this item's update lands
  sle_gather u_gather (
    .clk_i  (clk_i),
    .load_i (accept),
    .idx_i  (idx),
    .vals_i (cell_val),
    .data_o (gather_data)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (accept) state_d = StGather;
      StGather: state_d = StOut;
      StOut:    if (out_done) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      ok_q    <= 1'b0;
      rv_en_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ok_q    <= ok_d;
      rv_en_q <= rv_en_d;
    end
  end

  // result register, zero unless a stored value is returned
  always_ff @(posedge clk_i) begin
    if (state_q == StGather) begin
      res_q <= rv_en_q ? gather_data : '0;
    end
  end

  assign m_axis_tdata = {{(OutDataW-OutBits){1'b0}}, count_q, ok_q, res_q};

  `SLE_NEVER(a_count_range, count_q > CountW'(CAPACITY), "count above capacity")
  `SLE_ASSERT(a_result_latency, accept |-> ##2 m_axis_tvalid, "result not ready 2 cycles after accept")
  `SLE_ASSERT(a_insert_grows, accept && act == ACT_INSERT && !full |=> count_q == $past(count_q) + 1'b1, "insert did not grow count")
  `SLE_NEVER(a_value_without_ok, m_axis_tvalid && !ok_q && res_q != '0, "nonzero value with ok low")

endmodule

@@ rtl/sle_cell.sv @@
// One storage cell of the sorted chain.
// Depends on sle_pkg.
module sle_cell import sle_pkg::*; (
  input  logic                   clk_i,
  input  sle_cmd_t               cmd_i,
  input  logic                   valid_i,     // cell index below the count
  input  logic signed [ValW-1:0] x_i,         // value being inserted
  input  logic signed [ValW-1:0] left_val_i,
  input  logic                   left_gt_i,   // left neighbor holds a value larger than the inserted one
  input  logic signed [ValW-1:0] right_val_i,
  output logic signed [ValW-1:0] val_o,
  output logic                   gt_o
);

  logic signed [ValW-1:0] val_q;
  logic signed [ValW-1:0] val_d;

  // strictly greater: equal values stay ahead of the new one
  assign gt_o  = valid_i && (val_q > x_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (cmd_i.ins) begin
      if (left_gt_i) begin
        val_d = left_val_i;
      end else if (gt_o || !valid_i) begin
        val_d = x_i;
      end
    end else if (cmd_i.pop_min) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

@@ rtl/sle_gather.sv @@
// Two-stage registered select tree that picks one cell's value by index.
// Depends on sle_pkg.
module sle_gather import sle_pkg::*; (
  input  logic                   clk_i,
  input  logic                   load_i,
  input  logic [IdxW-1:0]        idx_i,
  input  logic signed [ValW-1:0] vals_i [CAPACITY],
  output logic signed [ValW-1:0] data_o
);

  logic signed [ValW-1:0] masked [Groups*GroupN];
  logic signed [ValW-1:0] part_d [Groups];
  logic signed [ValW-1:0] part_q [Groups];

  for (genvar i = 0; i < Groups * GroupN; i++) begin : g_mask
    if (i < CAPACITY) begin : g_real
      assign masked[i] = (idx_i == IdxW'(i)) ? vals_i[i] : '0;
    end else begin : g_pad
      assign masked[i] = '0;
    end
  end

  always_comb begin
    for (int g = 0; g < Groups; g++) begin
      part_d[g] = '0;
      for (int k = 0; k < GroupN; k++) begin
        part_d[g] = part_d[g] | masked[g*GroupN + k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      part_q <= part_d;
    end
  end

  // second stage: one-hot partials, a plain OR finishes the select
  always_comb begin
    data_o = '0;
    for (int g = 0; g < Groups; g++) begin
      data_o = data_o | part_q[g];
    end
  end

endmodule
